// ===== rtl/dpt_pkg.sv =====
// Package for the demand paging table walker: defaults, state codes,
// status codes and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
package dpt_pkg;
	localparam int TABLE_POOL  = 64;
	localparam int INDEX_BITS  = 9;
	localparam int FRAME_LIMIT = 65536;
	localparam int LEVELS      = 4;

	// status codes of a result word
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_POOL  = 2'd1;
	localparam logic [1:0] STAT_FRAME = 2'd2;

	typedef enum logic [3:0] {
		ST_RST_CLR, ST_IDLE, ST_READ, ST_EVAL, ST_DECIDE,
		ST_ROOT, ST_WRITE, ST_FREE_CLR, ST_FIN, ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic start;
		logic rd;
		logic eval;
		logic decide;
		logic root;
		logic wr;
		logic clr_start;
		logic clr;
		logic fin;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic root_present;
		logic rd_valid;
		logic lvl_last;
		logic clr_last;
		logic err;
		logic have_frame;
	} sts_t;
endpackage

// ===== rtl/dpt_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module dpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end
endmodule

// ===== rtl/dpt_ctrl.sv =====
// Walk sequencer: clearing pass, look-up reads, limit check, commit writes.
// Depends on dpt_pkg.
`timescale 1ns / 1ps
module dpt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          req_free,
	output logic          out_valid,
	input  logic          out_ready,
	input  dpt_pkg::sts_t sts,
	output dpt_pkg::cmd_t cmd
);
	dpt_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dpt_pkg::ST_RST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			dpt_pkg::ST_RST_CLR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) state_d = dpt_pkg::ST_IDLE;
			end
			dpt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					if (req_free) begin
						cmd.clr_start = 1'b1;
						state_d = dpt_pkg::ST_FREE_CLR;
					end else if (sts.root_present) begin
						state_d = dpt_pkg::ST_READ;
					end else begin
						state_d = dpt_pkg::ST_DECIDE;
					end
				end
			end
			dpt_pkg::ST_READ: begin
				cmd.rd = 1'b1;
				state_d = dpt_pkg::ST_EVAL;
			end
			dpt_pkg::ST_EVAL: begin
				cmd.eval = 1'b1;
				if (sts.rd_valid && !sts.lvl_last) state_d = dpt_pkg::ST_READ;
				else state_d = dpt_pkg::ST_DECIDE;
			end
			dpt_pkg::ST_DECIDE: begin
				cmd.decide = 1'b1;
				if (sts.err || sts.have_frame) state_d = dpt_pkg::ST_FIN;
				else if (!sts.root_present) state_d = dpt_pkg::ST_ROOT;
				else state_d = dpt_pkg::ST_WRITE;
			end
			dpt_pkg::ST_ROOT: begin
				cmd.root = 1'b1;
				state_d = dpt_pkg::ST_WRITE;
			end
			dpt_pkg::ST_WRITE: begin
				cmd.wr = 1'b1;
				if (sts.lvl_last) state_d = dpt_pkg::ST_FIN;
			end
			dpt_pkg::ST_FREE_CLR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) state_d = dpt_pkg::ST_FIN;
			end
			dpt_pkg::ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = dpt_pkg::ST_DONE;
			end
			dpt_pkg::ST_DONE: begin
				out_valid = 1'b1;
				if (out_ready) state_d = dpt_pkg::ST_IDLE;
			end
			default: state_d = dpt_pkg::ST_IDLE;
		endcase
	end

	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rd && (cmd.wr || cmd.clr)))
		else $error("read and write issued together");
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dpt_pkg::ST_DONE && !out_ready) |=> state_q == dpt_pkg::ST_DONE)
		else $error("result dropped while stalled");
	a_eval_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dpt_pkg::ST_EVAL) |-> $past(state_q) == dpt_pkg::ST_READ)
		else $error("read data used without a read");
endmodule

// ===== rtl/dpt_dpath.sv =====
// Walk datapath: indices, level and table registers, counters, entry store
// and result register. Depends on dpt_pkg and dpt_ram.
`timescale 1ns / 1ps
module dpt_dpath #(
	parameter int TABLE_POOL  = dpt_pkg::TABLE_POOL,
	parameter int INDEX_BITS  = dpt_pkg::INDEX_BITS,
	parameter int FRAME_LIMIT = dpt_pkg::FRAME_LIMIT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_type,
	input  logic [35:0]   page_number,
	input  dpt_pkg::cmd_t cmd,
	output dpt_pkg::sts_t sts,
	output logic [47:0]   result
);
	localparam int TW    = $clog2(TABLE_POOL);
	localparam int TCW   = $clog2(TABLE_POOL + 1);
	localparam int FCW   = $clog2(FRAME_LIMIT + 1);
	localparam int FW    = (FRAME_LIMIT > 1) ? $clog2(FRAME_LIMIT) : 1;
	localparam int PW    = (TW > FW) ? TW : FW;
	localparam int DW    = PW + 1;
	localparam int AW    = TW + INDEX_BITS;
	localparam int DEPTH = TABLE_POOL << INDEX_BITS;

	logic [INDEX_BITS-1:0] idx_q [dpt_pkg::LEVELS];
	logic [1:0]            lvl_q;
	logic [TW-1:0]         t_q, root_q;
	logic                  root_present_q, free_q, have_q;
	logic [TCW-1:0]        tu_q;
	logic [FCW-1:0]        fu_q;
	logic [2:0]            need_q;
	logic [FW-1:0]         fr_q;
	logic [1:0]            code_q;
	logic [AW-1:0]         clr_q;
	logic [47:0]           result_q;

	logic                  ram_we, ram_re;
	logic [AW-1:0]         ram_addr;
	logic [DW-1:0]         ram_wdata, ram_rdata;
	logic [TCW:0]          pool_sum;
	logic                  pool_err, frame_err, lvl_last;

	assign lvl_last  = (lvl_q == 2'd3);
	assign pool_sum  = (TCW + 1)'(tu_q) + (TCW + 1)'(need_q);
	assign pool_err  = pool_sum > (TCW + 1)'(TABLE_POOL);
	assign frame_err = !have_q && (fu_q >= FCW'(FRAME_LIMIT));

	// entry store port
	assign ram_we   = cmd.wr || cmd.clr;
	assign ram_re   = cmd.rd;
	assign ram_addr = cmd.clr ? clr_q : {t_q, idx_q[lvl_q]};
	always_comb begin
		if (cmd.clr) ram_wdata = '0;
		else if (lvl_last) ram_wdata = {1'b1, PW'(fu_q[FW-1:0])};
		else ram_wdata = {1'b1, PW'(tu_q[TW-1:0])};
	end

	dpt_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// walk state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q          <= '0;
			t_q            <= '0;
			root_q         <= '0;
			root_present_q <= 1'b0;
			free_q         <= 1'b0;
			have_q         <= 1'b0;
			tu_q           <= '0;
			fu_q           <= '0;
			need_q         <= '0;
			fr_q           <= '0;
			code_q         <= dpt_pkg::STAT_OK;
			clr_q          <= '0;
		end else begin
			if (cmd.start) begin
				lvl_q  <= '0;
				t_q    <= root_q;
				free_q <= req_type;
				have_q <= 1'b0;
				need_q <= root_present_q ? 3'd0 : 3'd4;
				code_q <= dpt_pkg::STAT_OK;
			end
			if (cmd.clr_start) begin
				clr_q          <= '0;
				tu_q           <= '0;
				fu_q           <= '0;
				root_q         <= '0;
				root_present_q <= 1'b0;
			end
			if (cmd.clr) clr_q <= clr_q + AW'(1);
			if (cmd.eval) begin
				if (ram_rdata[DW-1]) begin
					if (lvl_last) begin
						have_q <= 1'b1;
						fr_q   <= ram_rdata[FW-1:0];
					end else begin
						t_q   <= ram_rdata[TW-1:0];
						lvl_q <= lvl_q + 2'd1;
					end
				end else begin
					need_q <= 3'd3 - {1'b0, lvl_q};
				end
			end
			if (cmd.decide) begin
				if (pool_err) code_q <= dpt_pkg::STAT_POOL;
				else if (frame_err) code_q <= dpt_pkg::STAT_FRAME;
			end
			if (cmd.root) begin
				root_q         <= tu_q[TW-1:0];
				root_present_q <= 1'b1;
				t_q            <= tu_q[TW-1:0];
				tu_q           <= tu_q + TCW'(1);
			end
			if (cmd.wr) begin
				if (lvl_last) begin
					fr_q <= fu_q[FW-1:0];
					fu_q <= fu_q + FCW'(1);
				end else begin
					t_q   <= tu_q[TW-1:0];
					tu_q  <= tu_q + TCW'(1);
					lvl_q <= lvl_q + 2'd1;
				end
			end
		end
	end

	// page indices, top index first
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int l = 0; l < dpt_pkg::LEVELS; l++) begin
				idx_q[l] <= page_number[(3 - l) * INDEX_BITS +: INDEX_BITS];
			end
		end
	end

	// result word
	logic [31:0] fr_w, tu_w, fu_w;
	logic        ok;
	assign fr_w = 32'(fr_q);
	assign tu_w = 32'(tu_q);
	assign fu_w = 32'(fu_q);
	assign ok   = !free_q && (code_q == dpt_pkg::STAT_OK);

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			result_q <= {2'b00,
				free_q ? dpt_pkg::STAT_OK : code_q,
				fu_w[16:0],
				tu_w[6:0],
				ok ? need_q : 3'd0,
				ok && !have_q,
				ok ? fr_w[15:0] : 16'd0};
		end
	end
	assign result = result_q;

	assign sts.root_present = root_present_q;
	assign sts.rd_valid     = ram_rdata[DW-1];
	assign sts.lvl_last     = lvl_last;
	assign sts.clr_last     = (clr_q == AW'(DEPTH - 1));
	assign sts.err          = pool_err || frame_err;
	assign sts.have_frame   = have_q;
endmodule

// ===== rtl/demand_paging_table_walker_top.sv =====
// A walk runs a read state and an evaluate state per table read, one check, a state per commit
// write or new root, and a state to form the result; reads and writes share the single-port entry store.
// A free request clears all TABLE_POOL << INDEX_BITS entries, one per cycle.
// One item at a time; the next word is taken once the result word is taken.
// After reset a clearing pass over all TABLE_POOL << INDEX_BITS entries runs before
// the first word is accepted.
`timescale 1ns / 1ps
module demand_paging_table_walker_top #(
	parameter int TABLE_POOL  = dpt_pkg::TABLE_POOL,
	parameter int INDEX_BITS  = dpt_pkg::INDEX_BITS,
	parameter int FRAME_LIMIT = dpt_pkg::FRAME_LIMIT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // page_number[35:0]
	input  logic        s_tuser,  // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	// frame_number[15:0], frame_was_new[16], tables_added[19:17],
	// table_count[26:20], frame_count[43:27], status[45:44]
	output logic [47:0] m_tdata
);
	dpt_pkg::cmd_t cmd;
	dpt_pkg::sts_t sts;

	dpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.req_free  (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dpt_dpath #(
		.TABLE_POOL  (TABLE_POOL),
		.INDEX_BITS  (INDEX_BITS),
		.FRAME_LIMIT (FRAME_LIMIT)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_type    (s_tuser),
		.page_number (s_tdata[35:0]),
		.cmd         (cmd),
		.sts         (sts),
		.result      (m_tdata)
	);
endmodule
